FILE: rtl/core/fire_alarm_detector_door_table_unit_assert.svh
// assertion macros used by the rtl of the fire alarm door table unit
// no dependencies; included by fadt_back, which checks its own logic
`ifndef FIRE_ALARM_DETECTOR_DOOR_TABLE_UNIT_ASSERT_SVH
`define FIRE_ALARM_DETECTOR_DOOR_TABLE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define FADT_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("fadt assertion failed");
`define FADT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("fadt forbidden condition seen");
`else
`define FADT_ASSERT(label, clk, rst, prop)
`define FADT_NEVER(label, clk, rst, cond)
`endif
`endif

FILE: rtl/core/fadt_pkg.sv
// types, codes and sizes shared by the fire alarm door table unit
// no dependencies; imported by every module of the block
package fadt_pkg;

  localparam int DOOR_SLOTS  = 32;
  localparam int SLOT_W      = (DOOR_SLOTS > 1) ? $clog2(DOOR_SLOTS) : 1;
  localparam int CNT_W       = $clog2(DOOR_SLOTS + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int SINCE_W     = 25;
  localparam int CFG_W       = 24;

  localparam logic signed [15:0] THRESHOLD_RESET = 16'sd12800;
  localparam logic [7:0]         MIN_DET_RESET   = 8'd5;
  localparam logic [23:0]        PERIOD_RESET    = 24'd2000000;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_TEMP = 2'd1,
    CMD_FIRE = 2'd2,
    CMD_DOOR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_MIN_DET   = 2'd1,
    REG_PERIOD    = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    KIND_CONFIRM    = 2'd0,
    KIND_OPEN       = 2'd1,
    KIND_ALARM_ONLY = 2'd2
  } kind_t;

  typedef enum logic {
    OP_ALARM    = 1'b0,
    OP_REGISTER = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    B_IDLE   = 2'd0,
    B_EMIT   = 2'd1,
    B_SEARCH = 2'd2
  } bstate_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] addr;
    logic [15:0] port;
  } job_t;

  typedef struct packed {
    logic valid;
    logic full;
  } qstat_t;

endpackage

FILE: rtl/core/fadt_front.sv
// front end: takes requests, keeps the hot sample detector and config registers
// depends on fadt_pkg; pushes alarm and registration jobs into the queue
module fadt_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic [1:0]             cmd,
  input  logic signed [15:0]     temperature,
  input  logic [31:0]            dest_addr,
  input  logic [15:0]            dest_port,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [fadt_pkg::CFG_W-1:0] cfg_data,
  output logic                   push,
  output fadt_pkg::job_t         push_job
);
  import fadt_pkg::*;

  logic signed [15:0]   hot_thr;
  logic [7:0]           hot_limit;
  logic [23:0]          hot_window;
  logic [SINCE_W-1:0]   since_last_hot;
  logic [SINCE_W-1:0]   since_last_hot_next;
  logic [7:0]           hot_count;
  logic [7:0]           hot_count_next;
  logic [7:0]           hc_eff;
  logic                 hot;

  assign hot    = temperature >= hot_thr;
  // count restarts when the last hot sample is too old
  assign hc_eff = (since_last_hot > {1'b0, hot_window}) ? 8'd0 : hot_count;

  always_comb begin
    since_last_hot_next = since_last_hot;
    hot_count_next      = hot_count;
    push                = 1'b0;
    push_job.op         = OP_ALARM;
    push_job.addr       = dest_addr;
    push_job.port       = dest_port;
    if (accept) begin
      case (cmd_t'(cmd))
        CMD_TICK: begin
          if (since_last_hot != {SINCE_W{1'b1}}) begin
            since_last_hot_next = since_last_hot + SINCE_W'(1);
          end
        end
        CMD_TEMP: begin
          if (hot) begin
            since_last_hot_next = '0;
            if (hc_eff < hot_limit) begin
              hot_count_next = hc_eff + 8'd1;
            end else begin
              hot_count_next = hc_eff;
              push           = 1'b1;
            end
          end
        end
        CMD_FIRE: begin
          push = 1'b1;
        end
        CMD_DOOR: begin
          push        = 1'b1;
          push_job.op = OP_REGISTER;
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hot_thr        <= THRESHOLD_RESET;
      hot_limit      <= MIN_DET_RESET;
      hot_window     <= PERIOD_RESET;
      since_last_hot <= {SINCE_W{1'b1}};
      hot_count      <= '0;
    end else begin
      since_last_hot <= since_last_hot_next;
      hot_count      <= hot_count_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_THRESHOLD: hot_thr    <= cfg_data[15:0];
          REG_MIN_DET:   hot_limit  <= cfg_data[7:0];
          REG_PERIOD:    hot_window <= cfg_data[23:0];
          default:       ;
        endcase
      end
    end
  end

endmodule

FILE: rtl/core/fadt_queue.sv
// short job queue between the front end and the back end
// depends on fadt_pkg for the job type and depth
module fadt_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  fadt_pkg::job_t  push_job,
  input  logic            pop,
  output fadt_pkg::job_t  head,
  output fadt_pkg::qstat_t stat
);
  import fadt_pkg::*;

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head       = slots[rd_ptr];
  assign stat.valid = count != '0;
  assign stat.full  = count == QCNT_W'(QUEUE_DEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/core/fadt_back.sv
// back end: door table memory, alarm latch, open command and confirm sequencer
// depends on fadt_pkg and the assertion macro header
`include "fire_alarm_detector_door_table_unit_assert.svh"
module fadt_back (
  input  logic             clk,
  input  logic             rst,
  input  fadt_pkg::job_t   head,
  input  fadt_pkg::qstat_t qstat,
  output logic             pop,
  output logic             strobe,
  output logic [1:0]       kind,
  output logic [31:0]      out_addr,
  output logic [15:0]      out_port,
  output logic             alarm_active,
  output logic             last
);
  import fadt_pkg::*;

  logic [47:0]       table_mem [DOOR_SLOTS];

  bstate_t           state;
  bstate_t           state_next;
  job_t              job;
  logic [CNT_W-1:0]  held;
  logic              alarm_latch;
  logic [CNT_W-1:0]  rd_idx;
  logic [CNT_W-1:0]  data_idx;
  logic              data_vld;
  logic [47:0]       rdata;

  logic              issue;
  logic              hit;
  logic              at_end;
  logic              finish;
  logic              wr_en;
  logic [47:0]       wr_data;
  logic              res_vld;
  kind_t             res_kind;
  logic [31:0]       res_addr;
  logic [15:0]       res_port;
  logic              res_alarm;
  logic              res_last;

  assign hit    = data_vld && (rdata == {job.addr, job.port});
  assign at_end = data_vld && ((data_idx + CNT_W'(1)) == held);
  assign finish = (state == B_EMIT) ? at_end : (hit || at_end);

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (pop && held != '0) begin
          state_next = (head.op == OP_ALARM) ? B_EMIT : B_SEARCH;
        end
      end
      B_EMIT, B_SEARCH: begin
        if (finish) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    issue     = 1'b0;
    wr_en     = 1'b0;
    wr_data   = {job.addr, job.port};
    res_vld   = 1'b0;
    res_kind  = KIND_CONFIRM;
    res_addr  = job.addr;
    res_port  = job.port;
    res_alarm = alarm_latch;
    res_last  = 1'b1;
    case (state)
      B_IDLE: begin
        pop = qstat.valid;
        if (pop && held == '0) begin
          res_vld = 1'b1;
          if (head.op == OP_ALARM) begin
            res_kind  = KIND_ALARM_ONLY;
            res_addr  = '0;
            res_port  = '0;
            res_alarm = 1'b1;
          end else begin
            // empty table: no search needed
            wr_en    = 1'b1;
            wr_data  = {head.addr, head.port};
            res_addr = head.addr;
            res_port = head.port;
          end
        end
      end
      B_EMIT: begin
        issue = !finish && (rd_idx < held);
        if (data_vld) begin
          res_vld   = 1'b1;
          res_kind  = KIND_OPEN;
          res_addr  = rdata[47:16];
          res_port  = rdata[15:0];
          res_alarm = 1'b1;
          res_last  = at_end;
        end
      end
      B_SEARCH: begin
        issue = !finish && (rd_idx < held);
        if (at_end && !hit && held != CNT_W'(DOOR_SLOTS)) begin
          wr_en   = 1'b1;
          res_vld = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // one write port at the fill count, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[held[SLOT_W-1:0]] <= wr_data;
    end
    if (issue) begin
      rdata <= table_mem[rd_idx[SLOT_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= head;
    end
    if (issue) begin
      data_idx <= rd_idx;
    end
    kind         <= res_kind;
    out_addr     <= res_addr;
    out_port     <= res_port;
    alarm_active <= res_alarm;
    last         <= res_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= B_IDLE;
      held        <= '0;
      alarm_latch <= 1'b0;
      rd_idx      <= '0;
      data_vld    <= 1'b0;
      strobe      <= 1'b0;
    end else begin
      state    <= state_next;
      data_vld <= issue;
      strobe   <= res_vld;
      if (pop) begin
        rd_idx <= '0;
      end else if (issue) begin
        rd_idx <= rd_idx + CNT_W'(1);
      end
      if (pop && head.op == OP_ALARM) begin
        alarm_latch <= 1'b1;
      end
      if (wr_en) begin
        held <= held + CNT_W'(1);
      end
    end
  end

  `FADT_ASSERT(a_open_has_alarm, clk, rst, (strobe && kind == KIND_OPEN) |-> alarm_active)
  `FADT_NEVER(a_held_bound, clk, rst, held > CNT_W'(DOOR_SLOTS))
  `FADT_ASSERT(a_write_counts, clk, rst, wr_en |=> (held == $past(held) + CNT_W'(1)))

endmodule

FILE: rtl/core/fire_alarm_detector_door_table_unit.sv
// top level of the fire alarm detector with emergency door table
// depends on fadt_pkg, fadt_front, fadt_queue and fadt_back
//
// Requests: a request (cmd, temperature, dest_addr, dest_port) is taken at a
// rising edge with start high and busy low. Ticks and temperature samples are
// finished in the front end in the cycle they are taken. Fire events, alarm
// raising samples and door registrations go to a two entry job queue; busy is
// high only while that queue is full.
// Results: each result is on kind, out_addr, out_port, alarm_active and last
// for one cycle with strobe high. The receiver cannot stall; results are
// never held back. last marks the final result of a request.
// Jobs: a job leaves the queue when the back end is idle. An alarm then gives
// one open command per cycle, or one alarm only result with no doors. A
// registration reads the door memory one entry a cycle, stopping at a match;
// the single read port of the door memory sets this rate.
// Config: cfg_we, cfg_index, cfg_data write a register in the cycle given.
// Reset: synchronous rst restores register defaults, clears the alarm latch,
// detection count and door count; the door memory needs no clearing.
module fire_alarm_detector_door_table_unit (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             cmd,
  input  logic signed [15:0]     temperature,
  input  logic [31:0]            dest_addr,
  input  logic [15:0]            dest_port,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [fadt_pkg::CFG_W-1:0] cfg_data,
  output logic                   strobe,
  output logic [1:0]             kind,
  output logic [31:0]            out_addr,
  output logic [15:0]            out_port,
  output logic                   alarm_active,
  output logic                   last
);
  import fadt_pkg::*;

  logic   accept;
  logic   push;
  job_t   push_job;
  job_t   head;
  qstat_t qstat;
  logic   pop;

  assign busy   = qstat.full;
  assign accept = start && !busy;

  fadt_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .cmd         (cmd),
    .temperature (temperature),
    .dest_addr   (dest_addr),
    .dest_port   (dest_port),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .push        (push),
    .push_job    (push_job)
  );

  fadt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .stat     (qstat)
  );

  fadt_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .qstat        (qstat),
    .pop          (pop),
    .strobe       (strobe),
    .kind         (kind),
    .out_addr     (out_addr),
    .out_port     (out_port),
    .alarm_active (alarm_active),
    .last         (last)
  );

endmodule

FILE: dv/tb_fire_alarm_detector_door_table_unit.sv
// self-checking testbench for fire_alarm_detector_door_table_unit
// depends on fadt_pkg and the rtl of the block; runs directed requests, then
// random phases under several register settings, checking every result in order
module tb_fire_alarm_detector_door_table_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import fadt_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 100;
  localparam int REPORT_MAX = 10;
  // index 3 selects no register
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct {
    cmd_t        cmd;
    logic [15:0] temp;
    logic [31:0] addr;
    logic [15:0] port;
  } sensor_req_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] addr;
    logic [15:0] port;
    logic        alarm;
    logic        last;
  } door_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        cmd = CMD_TICK;
  logic signed [15:0] temperature = '0;
  logic [31:0]       dest_addr = '0;
  logic [15:0]       dest_port = '0;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_index = REG_THRESHOLD;
  logic [CFG_W-1:0]  cfg_data = '0;
  logic              strobe;
  logic [1:0]        kind;
  logic [31:0]       out_addr;
  logic [15:0]       out_port;
  logic              alarm_active;
  logic              last;

  fire_alarm_detector_door_table_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .temperature  (temperature),
    .dest_addr    (dest_addr),
    .dest_port    (dest_port),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .strobe       (strobe),
    .kind         (kind),
    .out_addr     (out_addr),
    .out_port     (out_port),
    .alarm_active (alarm_active),
    .last         (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sensor_req_t  req_queue[$];
  door_result_t due_results[$];
  logic         took = 1'b0;
  int           idle_pct = 0;
  int           bad_count = 0;
  int           cycle_count = 0;

  // detector state as the block should hold it
  logic signed [15:0] thr_r = THRESHOLD_RESET;
  logic [7:0]         min_det_r = MIN_DET_RESET;
  logic [23:0]        period_r = PERIOD_RESET;
  logic [SINCE_W-1:0] since_hot = '1;
  logic [7:0]         hot_cnt = '0;
  logic               alarm_latched = 1'b0;
  logic [31:0]        tbl_addr[DOOR_SLOTS];
  logic [15:0]        tbl_port[DOOR_SLOTS];
  int                 doors_held = 0;

  // register values as the stimulus sees them
  int          cur_thr = 12800;
  int          cur_min = 5;
  int          cur_period = 2000000;
  logic [31:0] seen_addr[$];
  logic [15:0] seen_port[$];

  function automatic void open_all_doors();
    alarm_latched = 1'b1;
    if (doors_held == 0) begin
      due_results.push_back('{KIND_ALARM_ONLY, 32'd0, 16'd0, 1'b1, 1'b1});
    end else begin
      for (int i = 0; i < doors_held; i++) begin
        due_results.push_back('{KIND_OPEN, tbl_addr[i], tbl_port[i], 1'b1,
                                (i == doors_held - 1)});
      end
    end
  endfunction

  function automatic void step_detector(cmd_t c, logic signed [15:0] t,
                                        logic [31:0] a, logic [15:0] p);
    case (c)
      CMD_TICK: begin
        if (since_hot != '1) since_hot = since_hot + 1'b1;
      end
      CMD_TEMP: begin
        if (t >= thr_r) begin
          // too long since the previous hot sample: count starts over
          if (since_hot > period_r) hot_cnt = '0;
          since_hot = '0;
          if (hot_cnt < min_det_r) hot_cnt = hot_cnt + 1'b1;
          else open_all_doors();
        end
      end
      CMD_FIRE: open_all_doors();
      default: begin
        for (int i = 0; i < doors_held; i++) begin
          if (tbl_addr[i] == a && tbl_port[i] == p) return;
        end
        if (doors_held >= DOOR_SLOTS) return;
        tbl_addr[doors_held] = a;
        tbl_port[doors_held] = p;
        doors_held++;
        due_results.push_back('{KIND_CONFIRM, a, p, alarm_latched, 1'b1});
      end
    endcase
  endfunction

  function automatic void report_bad(string what, door_result_t want);
    bad_count++;
    if (bad_count <= REPORT_MAX) begin
      $display("%0t %s: expected kind %0d addr %h port %h alarm %b last %b,",
               $realtime, what, want.kind, want.addr, want.port, want.alarm, want.last);
      $display("    got kind %0d addr %h port %h alarm %b last %b",
               kind, out_addr, out_port, alarm_active, last);
    end
  endfunction

  // monitor: results, register writes and accepted requests
  always @(posedge clk) begin
    door_result_t want;
    if (!rst) begin
      if (strobe !== 1'b0) begin
        if (due_results.size() == 0) begin
          report_bad("result with none due", '0);
        end else begin
          want = due_results.pop_front();
          if (kind !== want.kind || out_addr !== want.addr || out_port !== want.port ||
              alarm_active !== want.alarm || last !== want.last)
            report_bad("result mismatch", want);
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_THRESHOLD) thr_r = cfg_data[15:0];
        else if (cfg_index == REG_MIN_DET) min_det_r = cfg_data[7:0];
        else if (cfg_index == REG_PERIOD) period_r = cfg_data;
      end
      if (start && !busy) step_detector(cmd_t'(cmd), temperature, dest_addr, dest_port);
      took <= start && !busy;
    end
  end

  // driver: one request per handshake, random idle cycles between
  always @(negedge clk) begin
    sensor_req_t r;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || took) begin
      if (req_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        r = req_queue.pop_front();
        start <= 1'b1;
        cmd <= r.cmd;
        temperature <= r.temp;
        dest_addr <= r.addr;
        dest_port <= r.port;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_fire_alarm_detector_door_table_unit: errors");
      $finish;
    end
  end

  function automatic void push_req(cmd_t c, int t, logic [31:0] a, logic [15:0] p);
    req_queue.push_back('{c, 16'(t), a, p});
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_THRESHOLD) cur_thr = $signed(data[15:0]);
    else if (idx == REG_MIN_DET) cur_min = data[7:0];
    else if (idx == REG_PERIOD) cur_period = data;
  endtask

  // wait until every request is taken and every result has come, then let
  // requests that give no result finish inside the block
  task automatic settle();
    while (req_queue.size() != 0 || start || due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic int hot_temp();
    return cur_thr + int'($urandom_range(0, 32767 - cur_thr));
  endfunction

  function automatic void push_door(logic [31:0] a, logic [15:0] p);
    seen_addr.push_back(a);
    seen_port.push_back(p);
    push_req(CMD_DOOR, $urandom_range(0, 65535), a, p);
  endfunction

  // hot samples close enough together to reach the alarm
  function automatic int push_burst();
    int n_hot;
    int gap;
    int pushed;
    pushed = 0;
    n_hot = cur_min + 1 + $urandom_range(0, 1);
    for (int k = 0; k < n_hot; k++) begin
      gap = $urandom_range(0, (cur_period < 2) ? cur_period : 2);
      repeat (gap) push_req(CMD_TICK, $urandom_range(0, 65535), $urandom, $urandom_range(0, 65535));
      push_req(CMD_TEMP, hot_temp(), $urandom, $urandom_range(0, 65535));
      pushed += gap + 1;
    end
    return pushed;
  endfunction

  function automatic void push_random();
    int sel;
    int t;
    int pick;
    sel = $urandom_range(0, 99);
    if (sel < 25) begin
      push_req(CMD_TICK, $urandom_range(0, 65535), $urandom, $urandom_range(0, 65535));
    end else if (sel < 60) begin
      if ($urandom_range(0, 1) == 0) begin
        t = cur_thr + int'($urandom_range(0, 4)) - 2;
        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;
      end else begin
        t = $urandom_range(0, 65535);
      end
      push_req(CMD_TEMP, t, $urandom, $urandom_range(0, 65535));
    end else if (sel < 70) begin
      push_req(CMD_FIRE, $urandom_range(0, 65535), $urandom, $urandom_range(0, 65535));
    end else begin
      sel = $urandom_range(0, 9);
      if (seen_addr.size() != 0 && sel < 5) begin
        pick = $urandom_range(0, seen_addr.size() - 1);
        // same door again, or same address on another port
        if (sel < 4) push_door(seen_addr[pick], seen_port[pick]);
        else push_door(seen_addr[pick], $urandom_range(0, 65535));
      end else begin
        push_door($urandom, $urandom_range(0, 65535));
      end
    end
  endfunction

  task automatic run_phase(int count, int pct);
    int n;
    n = 0;
    idle_pct = pct;
    while (n < count) begin
      if ($urandom_range(0, 3) == 0 && cur_min < 8) begin
        n += push_burst();
      end else begin
        push_random();
        n++;
      end
    end
    settle();
  endtask

  initial begin
    int pick;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed requests at reset register values
    idle_pct = 0;
    push_req(CMD_TICK, 0, 0, 0);
    push_req(CMD_FIRE, 0, 0, 0);
    push_req(CMD_TEMP, 12799, 0, 0);
    push_req(CMD_TEMP, -32768, 0, 0);
    push_req(CMD_TEMP, 12800, 0, 0);
    push_req(CMD_TEMP, 32767, 0, 0);
    push_req(CMD_TICK, 0, 0, 0);
    push_req(CMD_TICK, 0, 0, 0);
    push_req(CMD_TEMP, 12800, 0, 0);
    push_req(CMD_TEMP, 32767, 0, 0);
    push_req(CMD_TEMP, 16'h7000, 0, 0);
    push_req(CMD_TEMP, 12800, 0, 0);
    push_door(32'h0000_0000, 16'h0000);
    push_door(32'hffff_ffff, 16'hffff);
    push_door(32'hffff_ffff, 16'hffff);
    push_door(32'hffff_ffff, 16'h0000);
    push_door(32'h0000_0000, 16'hffff);
    push_req(CMD_FIRE, 32767, 32'hffff_ffff, 16'hffff);
    push_req(CMD_TEMP, 32767, 0, 0);
    push_req(CMD_TICK, -1, 32'hffff_ffff, 16'hffff);
    settle();

    // every hot sample alarms, any tick restarts the count
    write_reg(REG_THRESHOLD, {8'($urandom), 16'($urandom_range(0, 4095) - 2048)});
    write_reg(REG_MIN_DET, {16'($urandom), 8'd0});
    write_reg(REG_PERIOD, 24'd0);
    run_phase(35, 61);

    // every sample hot, count never reaches the limit
    write_reg(REG_THRESHOLD, {8'($urandom), 16'h8000});
    write_reg(REG_MIN_DET, {16'($urandom), 8'd255});
    write_reg(REG_PERIOD, 24'hff_ffff);
    write_reg(REG_UNUSED, 24'($urandom));
    run_phase(25, 37);

    // fill the table, then try more doors and a fire with every slot held
    write_reg(REG_THRESHOLD, {8'($urandom), 16'h7fff});
    write_reg(REG_MIN_DET, {16'($urandom), 8'd2});
    write_reg(REG_PERIOD, 24'd3);
    idle_pct = 61;
    repeat (DOOR_SLOTS + 2) push_door($urandom, $urandom_range(0, 65535));
    repeat (3) begin
      pick = $urandom_range(0, seen_addr.size() - 1);
      push_door(seen_addr[pick], seen_port[pick]);
    end
    push_req(CMD_FIRE, $urandom_range(0, 65535), $urandom, $urandom_range(0, 65535));
    run_phase(25, 0);

    write_reg(REG_THRESHOLD, {8'($urandom), 16'($urandom)});
    write_reg(REG_MIN_DET, {16'($urandom), 8'($urandom_range(0, 4))});
    write_reg(REG_PERIOD, 24'($urandom_range(0, 10)));
    run_phase(30, 37);

    bad_count += due_results.size();
    if (bad_count == 0) begin
      $display("tb_fire_alarm_detector_door_table_unit: clean");
    end else begin
      $display("tb_fire_alarm_detector_door_table_unit: errors");
    end
    $finish;
  end

endmodule
